@@ hdl/lnrast_pkg.sv @@
package lnrast_pkg;

  // Default coordinate width and fixed color width
  localparam int unsigned CoordBitsDef = 6;
  localparam int unsigned ColorBits    = 32;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;  // capture a new line command and set up the walk
    logic step;  // emit one pixel and advance along the major axis
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic at_end;  // major position has reached the far endpoint
  } dp_status_t;

endpackage

@@ hdl/lnrast_datapath.sv @@
module lnrast_datapath #(
  parameter int unsigned CoordBits = lnrast_pkg::CoordBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lnrast_pkg::ctrl_cmd_t          cmd_i,
  output lnrast_pkg::dp_status_t         status_o,
  input  logic [CoordBits-1:0]           start_x_i,
  input  logic [CoordBits-1:0]           start_y_i,
  input  logic [CoordBits-1:0]           end_x_i,
  input  logic [CoordBits-1:0]           end_y_i,
  input  logic [lnrast_pkg::ColorBits-1:0] pixel_color_i,
  output logic                           pixel_valid_o,
  output logic [CoordBits-1:0]           pixel_x_o,
  output logic [CoordBits-1:0]           pixel_y_o,
  output logic [lnrast_pkg::ColorBits-1:0] write_color_o,
  output logic                           last_o
);

  localparam int unsigned ErrBits = CoordBits + 3;

  // Setup signals
  logic [CoordBits-1:0] adx, ady;
  logic                 steep;
  logic [CoordBits-1:0] a0, b0, a1, b1;
  logic [CoordBits-1:0] maj0, min0, maj1, min1;
  logic [CoordBits-1:0] dmaj, dmin;

  // Walk state
  logic [CoordBits-1:0]   major_pos_q, major_pos_d;
  logic [CoordBits-1:0]   minor_pos_q, minor_pos_d;
  logic [CoordBits-1:0]   major_end_q, major_end_d;
  logic [CoordBits-1:0]   major_delta_q, major_delta_d;
  logic signed [ErrBits-1:0] error_acc_q, error_acc_d;
  logic [CoordBits:0]     error_inc_q, error_inc_d;
  logic [CoordBits:0]     twice_major_delta_q, twice_major_delta_d;
  logic                   steep_flag_q, steep_flag_d;
  logic                   step_up_q, step_up_d;
  logic [lnrast_pkg::ColorBits-1:0] held_color_q, held_color_d;

  // Output registers
  logic                   valid_q, valid_d;
  logic [CoordBits-1:0]   px_q, px_d, py_q, py_d;
  logic [lnrast_pkg::ColorBits-1:0] color_q, color_d;
  logic                   last_q, last_d;

  logic signed [ErrBits-1:0] err_sum;
  logic                      minor_step;

  // Decide steepness, swap axes, order endpoints along the major axis
  always_comb begin
    adx   = (start_x_i > end_x_i) ? start_x_i - end_x_i : end_x_i - start_x_i;
    ady   = (start_y_i > end_y_i) ? start_y_i - end_y_i : end_y_i - start_y_i;
    steep = adx < ady;
    a0    = steep ? start_y_i : start_x_i;
    b0    = steep ? start_x_i : start_y_i;
    a1    = steep ? end_y_i   : end_x_i;
    b1    = steep ? end_x_i   : end_y_i;
    if (a0 > a1) begin
      maj0 = a1;
      min0 = b1;
      maj1 = a0;
      min1 = b0;
    end else begin
      maj0 = a0;
      min0 = b0;
      maj1 = a1;
      min1 = b1;
    end
    dmaj = maj1 - maj0;
    dmin = (min0 > min1) ? min0 - min1 : min1 - min0;
  end

  // Accumulate error and test against the major delta
  always_comb begin
    err_sum    = error_acc_q + $signed({2'b00, error_inc_q});
    minor_step = err_sum > $signed({3'b000, major_delta_q});
  end

  // Next-state for the walk registers and the output stage
  always_comb begin
    major_pos_d         = major_pos_q;
    minor_pos_d         = minor_pos_q;
    major_end_d         = major_end_q;
    major_delta_d       = major_delta_q;
    error_acc_d         = error_acc_q;
    error_inc_d         = error_inc_q;
    twice_major_delta_d = twice_major_delta_q;
    steep_flag_d        = steep_flag_q;
    step_up_d           = step_up_q;
    held_color_d        = held_color_q;
    valid_d             = 1'b0;
    px_d                = px_q;
    py_d                = py_q;
    color_d             = color_q;
    last_d              = last_q;

    if (cmd_i.load) begin
      major_pos_d         = maj0;
      minor_pos_d         = min0;
      major_end_d         = maj1;
      major_delta_d       = dmaj;
      error_acc_d         = '0;
      error_inc_d         = {dmin, 1'b0};
      twice_major_delta_d = {dmaj, 1'b0};
      steep_flag_d        = steep;
      step_up_d           = min1 > min0;
      held_color_d        = pixel_color_i;
    end else if (cmd_i.step) begin
      // Emit the current pixel, swapping back for steep lines
      valid_d = 1'b1;
      px_d    = steep_flag_q ? minor_pos_q : major_pos_q;
      py_d    = steep_flag_q ? major_pos_q : minor_pos_q;
      color_d = held_color_q;
      last_d  = major_pos_q == major_end_q;
      // Advance along the line
      major_pos_d = major_pos_q + 1'b1;
      if (minor_step) begin
        minor_pos_d = step_up_q ? minor_pos_q + 1'b1 : minor_pos_q - 1'b1;
        error_acc_d = err_sum - $signed({2'b00, twice_major_delta_q});
      end else begin
        error_acc_d = err_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_pos_q         <= '0;
      minor_pos_q         <= '0;
      major_end_q         <= '0;
      major_delta_q       <= '0;
      error_acc_q         <= '0;
      error_inc_q         <= '0;
      twice_major_delta_q <= '0;
      steep_flag_q        <= 1'b0;
      step_up_q           <= 1'b0;
      held_color_q        <= '0;
      valid_q             <= 1'b0;
    end else begin
      major_pos_q         <= major_pos_d;
      minor_pos_q         <= minor_pos_d;
      major_end_q         <= major_end_d;
      major_delta_q       <= major_delta_d;
      error_acc_q         <= error_acc_d;
      error_inc_q         <= error_inc_d;
      twice_major_delta_q <= twice_major_delta_d;
      steep_flag_q        <= steep_flag_d;
      step_up_q           <= step_up_d;
      held_color_q        <= held_color_d;
      valid_q             <= valid_d;
    end
  end

  // Output payload holds without reset
  always_ff @(posedge clk_i) begin
    px_q    <= px_d;
    py_q    <= py_d;
    color_q <= color_d;
    last_q  <= last_d;
  end

  assign status_o.at_end = major_pos_q == major_end_q;
  assign pixel_valid_o   = valid_q;
  assign pixel_x_o       = px_q;
  assign pixel_y_o       = py_q;
  assign write_color_o   = color_q;
  assign last_o          = last_q;

endmodule

@@ hdl/lnrast_ctrl.sv @@
module lnrast_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  lnrast_pkg::dp_status_t status_i,
  output lnrast_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic {
    StIdle,
    StWalk
  } state_e;

  state_e state_q, state_d;

  // Load on an accepted item, step every walk cycle
  always_comb begin
    cmd_o.load = start && (state_q == StIdle);
    cmd_o.step = state_q == StWalk;
  end

  // Leave the walk after the final pixel
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start) state_d = StWalk;
      end
      StWalk: begin
        if (status_i.at_end) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = state_q != StIdle;

endmodule

@@ hdl/line_rasterizer_core.sv @@
// Line command in, one pixel write per cycle out.
// The command is captured into the walk registers at the accept edge, and the first pixel
// is then strobed from the output registers after the first walk step. A line has at most
// 64 pixels at 6-bit coordinates, emitted one per cycle; a new command is taken only when idle.
// Reset (rst_ni low, asynchronous) returns the block to idle with no strobe pending.
// Results are strobed for one cycle each; the receiver cannot stall them.
module line_rasterizer_core #(
  parameter int unsigned CoordBits = lnrast_pkg::CoordBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [CoordBits-1:0]             start_x_i,
  input  logic [CoordBits-1:0]             start_y_i,
  input  logic [CoordBits-1:0]             end_x_i,
  input  logic [CoordBits-1:0]             end_y_i,
  input  logic [lnrast_pkg::ColorBits-1:0] pixel_color_i,
  output logic                             pixel_valid_o,
  output logic [CoordBits-1:0]             pixel_x_o,
  output logic [CoordBits-1:0]             pixel_y_o,
  output logic [lnrast_pkg::ColorBits-1:0] write_color_o,
  output logic                             last_o
);

  lnrast_pkg::ctrl_cmd_t  cmd;
  lnrast_pkg::dp_status_t status;

  // Sequence the line walk
  lnrast_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Set up and step the Bresenham error loop
  lnrast_datapath #(
    .CoordBits (CoordBits)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .pixel_color_i (pixel_color_i),
    .pixel_valid_o (pixel_valid_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .write_color_o (write_color_o),
    .last_o        (last_o)
  );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CW         = lnrast_pkg::CoordBitsDef;
  localparam int unsigned CoordMax   = (1 << CW) - 1;
  localparam int unsigned NumDir     = 18;
  localparam int unsigned NumPhases  = 4;
  localparam int unsigned PhaseItems = 55;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned TailCycles = 80;

  typedef logic [CW-1:0] coord_t;

  typedef struct packed {
    coord_t                             x;
    coord_t                             y;
    logic [lnrast_pkg::ColorBits-1:0]   color;
    logic                               last;
  } pixel_t;

  // One directed line command; typed rows carry a hand-read pixel count and end pixels
  typedef struct packed {
    coord_t      sx;
    coord_t      sy;
    coord_t      ex;
    coord_t      ey;
    logic [31:0] col;
    logic        typed;
    logic [7:0]  n;
    coord_t      fx;
    coord_t      fy;
    coord_t      lx;
    coord_t      ly;
  } line_row_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             start;
  logic                             busy;
  coord_t                           start_x_i;
  coord_t                           start_y_i;
  coord_t                           end_x_i;
  coord_t                           end_y_i;
  logic [lnrast_pkg::ColorBits-1:0] pixel_color_i;
  logic                             pixel_valid_o;
  coord_t                           pixel_x_o;
  coord_t                           pixel_y_o;
  logic [lnrast_pkg::ColorBits-1:0] write_color_o;
  logic                             last_o;

  pixel_t      pending_pixels[$];
  int unsigned mismatches;
  int unsigned lines_drawn;
  int unsigned zero_lines;
  int unsigned steep_lines;
  int unsigned pixels_checked;
  int unsigned cycle_count;

  line_rasterizer_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .pixel_color_i (pixel_color_i),
    .pixel_valid_o (pixel_valid_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .write_color_o (write_color_o),
    .last_o        (last_o)
  );

  // Directed lines: extremes, reversed ends, diagonal ties, steep and shallow walks
  line_row_t dir_rows [NumDir] = '{
    '{6'd0,  6'd0,  6'd0,  6'd0,  32'h0000_0000, 1'b1, 8'd1,  6'd0,  6'd0,  6'd0,  6'd0},
    '{6'd63, 6'd63, 6'd63, 6'd63, 32'hFFFF_FFFF, 1'b1, 8'd1,  6'd63, 6'd63, 6'd63, 6'd63},
    '{6'd0,  6'd0,  6'd63, 6'd0,  32'hAAAA_AAAA, 1'b1, 8'd64, 6'd0,  6'd0,  6'd63, 6'd0},
    '{6'd63, 6'd0,  6'd0,  6'd0,  32'h5555_5555, 1'b1, 8'd64, 6'd0,  6'd0,  6'd63, 6'd0},
    '{6'd0,  6'd0,  6'd0,  6'd63, 32'h1234_5678, 1'b1, 8'd64, 6'd0,  6'd0,  6'd0,  6'd63},
    '{6'd0,  6'd63, 6'd0,  6'd0,  32'h8765_4321, 1'b1, 8'd64, 6'd0,  6'd0,  6'd0,  6'd63},
    '{6'd0,  6'd0,  6'd63, 6'd63, 32'hFF00_FF00, 1'b1, 8'd64, 6'd0,  6'd0,  6'd63, 6'd63},
    '{6'd63, 6'd0,  6'd0,  6'd63, 32'h00FF_00FF, 1'b1, 8'd64, 6'd0,  6'd63, 6'd63, 6'd0},
    '{6'd0,  6'd63, 6'd63, 6'd0,  32'hDEAD_BEEF, 1'b1, 8'd64, 6'd0,  6'd63, 6'd63, 6'd0},
    '{6'd33, 6'd33, 6'd34, 6'd33, 32'hCAFE_F00D, 1'b1, 8'd2,  6'd33, 6'd33, 6'd34, 6'd33},
    '{6'd10, 6'd10, 6'd20, 6'd15, 32'h0102_0304, 1'b0, 8'd0,  6'd0,  6'd0,  6'd0,  6'd0},
    '{6'd20, 6'd15, 6'd10, 6'd10, 32'hF0F0_F0F0, 1'b0, 8'd0,  6'd0,  6'd0,  6'd0,  6'd0},
    '{6'd10, 6'd20, 6'd15, 6'd10, 32'h0F0F_0F0F, 1'b0, 8'd0,  6'd0,  6'd0,  6'd0,  6'd0},
    '{6'd5,  6'd40, 6'd6,  6'd3,  32'h8000_0001, 1'b0, 8'd0,  6'd0,  6'd0,  6'd0,  6'd0},
    '{6'd1,  6'd2,  6'd2,  6'd3,  32'h7FFF_FFFE, 1'b0, 8'd0,  6'd0,  6'd0,  6'd0,  6'd0},
    '{6'd0,  6'd1,  6'd63, 6'd62, 32'h3C3C_C3C3, 1'b0, 8'd0,  6'd0,  6'd0,  6'd0,  6'd0},
    '{6'd62, 6'd0,  6'd0,  6'd63, 32'hC3C3_3C3C, 1'b0, 8'd0,  6'd0,  6'd0,  6'd0,  6'd0},
    '{6'd63, 6'd63, 6'd0,  6'd62, 32'h0000_FFFF, 1'b0, 8'd0,  6'd0,  6'd0,  6'd0,  6'd0}
  };

  // Walk the line in ascending major order and return whether it is steep
  function automatic bit trace_line(input coord_t ax, input coord_t ay, input coord_t bx,
                                    input coord_t by, input logic [31:0] color,
                                    ref pixel_t pts[$]);
    int     x0;
    int     y0;
    int     x1;
    int     y1;
    int     tmp;
    int     dmaj;
    int     rise;
    int     fall;
    int     err;
    int     mn;
    bit     steep;
    bit     up;
    pixel_t p;
    x0 = ax;
    y0 = ay;
    x1 = bx;
    y1 = by;
    steep = ((x0 > x1) ? x0 - x1 : x1 - x0) < ((y0 > y1) ? y0 - y1 : y1 - y0);
    if (steep) begin
      tmp = x0; x0 = y0; y0 = tmp;
      tmp = x1; x1 = y1; y1 = tmp;
    end
    if (x0 > x1) begin
      tmp = x0; x0 = x1; x1 = tmp;
      tmp = y0; y0 = y1; y1 = tmp;
    end
    dmaj = x1 - x0;
    rise = 2 * ((y0 > y1) ? y0 - y1 : y1 - y0);
    fall = 2 * dmaj;
    up   = y1 > y0;
    err  = 0;
    mn   = y0;
    pts.delete();
    for (int maj = x0; maj <= x1; maj++) begin
      p.x     = steep ? coord_t'(mn) : coord_t'(maj);
      p.y     = steep ? coord_t'(maj) : coord_t'(mn);
      p.color = color;
      p.last  = (maj == x1);
      pts.push_back(p);
      err += rise;
      if (err > dmaj) begin
        mn  += up ? 1 : -1;
        err -= fall;
      end
    end
    return steep;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Bound the run length
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d pixels pending", cycle_count,
               pending_pixels.size());
      $display("** line_rasterizer_core: FAILED **");
      $finish;
    end
  end

  // Check each strobed pixel, then queue the pixels of a newly accepted line
  always @(posedge clk_i) begin : pixel_check
    pixel_t want;
    pixel_t walk[$];
    if (rst_ni) begin
      if (pixel_valid_o) begin
        pixels_checked++;
        if (pending_pixels.size() == 0) begin
          flag_mismatch($sformatf("pixel (%0d,%0d) strobed with none pending",
                                  pixel_x_o, pixel_y_o));
        end else begin
          want = pending_pixels.pop_front();
          if (pixel_x_o !== want.x)
            flag_mismatch($sformatf("pixel_x %0d, want %0d", pixel_x_o, want.x));
          if (pixel_y_o !== want.y)
            flag_mismatch($sformatf("pixel_y %0d, want %0d", pixel_y_o, want.y));
          if (write_color_o !== want.color)
            flag_mismatch($sformatf("write_color %h, want %h", write_color_o, want.color));
          if (last_o !== want.last)
            flag_mismatch($sformatf("last %b, want %b at (%0d,%0d)", last_o, want.last,
                                    want.x, want.y));
        end
      end
      if (start && !busy) begin
        lines_drawn++;
        if (trace_line(start_x_i, start_y_i, end_x_i, end_y_i, pixel_color_i, walk))
          steep_lines++;
        if (walk.size() == 1) zero_lines++;
        foreach (walk[i]) pending_pixels.push_back(walk[i]);
      end
    end
  end

  // Present one line command at the falling edge and hold it until accepted
  task automatic send_line(input coord_t sx, input coord_t sy, input coord_t ex,
                           input coord_t ey, input logic [31:0] col);
    @(negedge clk_i);
    start         = 1'b1;
    start_x_i     = sx;
    start_y_i     = sy;
    end_x_i       = ex;
    end_y_i       = ey;
    pixel_color_i = col;
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start for a while and scramble the fields meanwhile
  task automatic hold_idle(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start         = 1'b0;
      start_x_i     = coord_t'($urandom);
      start_y_i     = coord_t'($urandom);
      end_x_i       = coord_t'($urandom);
      end_y_i       = coord_t'($urandom);
      pixel_color_i = $urandom;
    end
  endtask

  task automatic drain_pending();
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  function automatic coord_t clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > int'(CoordMax)) return coord_t'(CoordMax);
    return coord_t'(v);
  endfunction

  // Pick a random line: half arbitrary, plus short, point, axis, diagonal and corner lines
  task automatic pick_line(output coord_t sx, output coord_t sy, output coord_t ex,
                           output coord_t ey);
    int unsigned mode;
    int          d;
    mode = $urandom_range(0, 99);
    sx = coord_t'($urandom);
    sy = coord_t'($urandom);
    ex = coord_t'($urandom);
    ey = coord_t'($urandom);
    if (mode < 50) begin
      // arbitrary endpoints
    end else if (mode < 70) begin
      ex = clamp_coord(int'(sx) + int'($urandom_range(0, 8)) - 4);
      ey = clamp_coord(int'(sy) + int'($urandom_range(0, 8)) - 4);
    end else if (mode < 80) begin
      ex = sx;
      ey = sy;
    end else if (mode < 85) begin
      ey = sy;
    end else if (mode < 90) begin
      ex = sx;
    end else if (mode < 95) begin
      d = (ex > sx) ? ex - sx : sx - ex;
      if (int'(sy) + d <= int'(CoordMax)) ey = coord_t'(int'(sy) + d);
      else if (int'(sy) - d >= 0) ey = coord_t'(int'(sy) - d);
      else ey = sy;
    end else begin
      sx = $urandom_range(0, 1) ? coord_t'(CoordMax) : '0;
      sy = $urandom_range(0, 1) ? coord_t'(CoordMax) : '0;
      ex = $urandom_range(0, 1) ? coord_t'(CoordMax) : '0;
      ey = $urandom_range(0, 1) ? coord_t'(CoordMax) : '0;
    end
  endtask

  // Stimulus
  initial begin : stimulus
    int unsigned idle_pct [NumPhases];
    pixel_t      walk[$];
    bit          steep;
    coord_t      sx;
    coord_t      sy;
    coord_t      ex;
    coord_t      ey;
    start         = 1'b0;
    start_x_i     = '0;
    start_y_i     = '0;
    end_x_i       = '0;
    end_y_i       = '0;
    pixel_color_i = '0;
    rst_ni        = 1'b0;
    // The receiver cannot stall, so the phases vary only the sender's idling: none, 65, none, 36 in 100
    idle_pct = '{0, 65, 0, 36};
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed lines, back to back
    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) begin
        steep = trace_line(dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].ex, dir_rows[i].ey,
                           dir_rows[i].col, walk);
        if (walk.size() != dir_rows[i].n || walk[0].x != dir_rows[i].fx ||
            walk[0].y != dir_rows[i].fy || walk[walk.size()-1].x != dir_rows[i].lx ||
            walk[walk.size()-1].y != dir_rows[i].ly)
          flag_mismatch($sformatf("directed line %0d disagrees with its table entry", i));
      end
      send_line(dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].ex, dir_rows[i].ey,
                dir_rows[i].col);
    end
    hold_idle(1);
    drain_pending();

    // Random lines in phases of sender idling, pausing for a full drain between phases
    for (int ph = 0; ph < NumPhases; ph++) begin
      for (int k = 0; k < PhaseItems; k++) begin
        pick_line(sx, sy, ex, ey);
        send_line(sx, sy, ex, ey, $urandom);
        if ($urandom_range(1, 100) <= idle_pct[ph])
          hold_idle($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : $urandom_range(1, 70));
      end
      hold_idle(1);
      drain_pending();
    end

    // Let any stray pixel show up before closing
    repeat (TailCycles) @(posedge clk_i);
    $display("Drew %0d lines (%0d single-pixel, %0d steep), checked %0d pixel writes",
             lines_drawn, zero_lines, steep_lines, pixels_checked);
    $display("Sender idling phases: none, 65 in 100, none, 36 in 100; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("** line_rasterizer_core: PASSED **");
    end else begin
      $display("** line_rasterizer_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ line_rasterizer_core.f @@
hdl/lnrast_pkg.sv
hdl/lnrast_datapath.sv
hdl/lnrast_ctrl.sv
hdl/line_rasterizer_core.sv
tb/tb.sv
